// ----- sv/rpa_pkg.sv -----
package rpa_pkg;

    // sizing of the managed region
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int ADDR_W     = 32;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 3;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int TOP_W      = $clog2(NUM_PAGES + 1);
    localparam int PG_W       = ADDR_W - PAGE_SHIFT;

    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    // configuration register reset values
    localparam logic [ADDR_W-1:0] BASE_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] KEND_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] TOP_RST  = 32'h8800_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDR       = 2'd0,
        REG_KERNEL_END_ADDR = 2'd1,
        REG_TOP_ADDR        = 2'd2
    } t_cfg_reg;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INC   = 2'd2,
        ACT_SEED  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_BADADDR = 3'd2,
        STAT_UNDER   = 3'd3,
        STAT_FULL    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEND,
        ST_TOP,
        ST_BASE,
        ST_RD,
        ST_RMW,
        ST_POP,
        ST_GRANT,
        ST_DONE
    } t_state;

endpackage

// ----- sv/rpa_if.sv -----
// request channel: action and page address
interface rpa_req_if import rpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] page_addr;

    modport source(output valid, action, page_addr, input ready);
    modport sink(input valid, action, page_addr, output ready);
endinterface

// response channel: one result per request
interface rpa_rsp_if import rpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_addr;
    logic              page_released;
    logic [CNT_W-1:0]  ref_count;

    modport source(output valid, status, granted_addr, page_released, ref_count,
                   input ready);
    modport sink(input valid, status, granted_addr, page_released, ref_count,
                 output ready);
endinterface

// configuration write channel
interface rpa_cfg_if import rpa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [ADDR_W-1:0]    data;

    modport source(output valid, reg_index, data, input ready);
    modport sink(input valid, reg_index, data, output ready);
endinterface

// ----- sv/refcounted_page_allocator_top.sv -----
// Page allocator with a LIFO free stack and a 16-bit reference count per page.
// Each request gives exactly one response. An allocate that finds the pool
// empty, and a free, increment or seed whose address is rejected, go
// straight to the response. A single shared 33-bit add/subtract unit
// performs the three address bound checks and the granted-address add one
// per cycle, and the count memory is read through a register before its
// read-modify-write. A request is taken only while the sequencer is idle;
// a finished response waits in an output register, so the next request may
// be accepted before it is taken. After reset the count memory is zeroed by
// a clearing pass over all NUM_PAGES entries (32768 by default), during
// which no request is accepted; configuration writes are taken in every
// cycle, and must only be issued while idle.
module refcounted_page_allocator_top import rpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpa_req_if.sink    i_req,
    rpa_rsp_if.source  o_rsp,
    rpa_cfg_if.sink    i_cfg
);

    // configuration registers
    logic [ADDR_W-1:0] r_base, r_kend, r_top_addr;

    // sequencer and working registers
    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr, n_clr;
    logic [TOP_W-1:0]  r_top, n_top;
    t_action           r_action, n_action;
    logic [ADDR_W-1:0] r_pa, n_pa;
    logic [IDX_W-1:0]  r_idx, n_idx;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_granted, n_granted;
    logic              r_released, n_released;
    logic [CNT_W-1:0]  r_count, n_count;

    // output register
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_granted, n_out_granted;
    logic              r_out_released, n_out_released;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    // memories
    logic [CNT_W-1:0]  ref_mem [NUM_PAGES];
    logic [IDX_W-1:0]  stk_mem [NUM_PAGES];
    logic [CNT_W-1:0]  r_ref_rd;
    logic [IDX_W-1:0]  r_stk_rd;

    logic              ref_we;
    logic [IDX_W-1:0]  ref_waddr;
    logic [CNT_W-1:0]  ref_wdata;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_raddr;

    // shared add/subtract unit
    logic [ADDR_W-1:0] alu_a, alu_b;
    logic              alu_sub;
    logic [ADDR_W:0]   alu_res;
    logic              alu_carry;
    logic [PG_W-1:0]   alu_page;

    logic              req_fire;
    logic              out_free;
    logic [CNT_W-1:0]  cnt_base, cnt_dec;

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_addr  = r_out_granted;
    assign o_rsp.page_released = r_out_released;
    assign o_rsp.ref_count     = r_out_count;

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= BASE_RST;
            r_kend     <= KEND_RST;
            r_top_addr <= TOP_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.reg_index)
                REG_BASE_ADDR:       r_base     <= i_cfg.data;
                REG_KERNEL_END_ADDR: r_kend     <= i_cfg.data;
                REG_TOP_ADDR:        r_top_addr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // operand selection for the shared unit
    always_comb begin
        alu_a   = r_pa;
        alu_b   = r_base;
        alu_sub = 1'b1;
        case (r_state)
            ST_KEND: alu_b = r_kend;
            ST_TOP:  alu_b = r_top_addr;
            ST_BASE: alu_b = r_base;
            ST_GRANT: begin
                alu_a   = r_base;
                alu_b   = ADDR_W'(r_stk_rd) << PAGE_SHIFT;
                alu_sub = 1'b0;
            end
            default: ;
        endcase
    end

    // carry out of a subtract means no borrow, a >= b
    assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{ADDR_W{1'b0}}, alu_sub};
    assign alu_carry = alu_res[ADDR_W];
    assign alu_page  = alu_res[ADDR_W-1:PAGE_SHIFT];

    assign stk_raddr = IDX_W'(r_top - TOP_W'(1));

    // count arithmetic for the read-modify-write step
    assign cnt_base = (r_action == ACT_SEED) ? CNT_W'(1) : r_ref_rd;
    assign cnt_dec  = cnt_base - CNT_W'(1);

    // sequencer: next state and datapath control
    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        n_top          = r_top;
        n_action       = r_action;
        n_pa           = r_pa;
        n_idx          = r_idx;
        n_status       = r_status;
        n_granted      = r_granted;
        n_released     = r_released;
        n_count        = r_count;
        n_out_valid    = r_out_valid && !o_rsp.ready;
        n_out_status   = r_out_status;
        n_out_granted  = r_out_granted;
        n_out_released = r_out_released;
        n_out_count    = r_out_count;
        ref_we         = 1'b0;
        ref_waddr      = r_idx;
        ref_wdata      = '0;
        stk_we         = 1'b0;

        case (r_state)
            // zero the count memory one entry a cycle
            ST_CLEAR: begin
                ref_we    = 1'b1;
                ref_waddr = r_clr;
                n_clr     = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(NUM_PAGES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_fire) begin
                    n_action   = t_action'(i_req.action);
                    n_pa       = i_req.page_addr;
                    n_status   = STAT_OK;
                    n_granted  = '0;
                    n_released = 1'b0;
                    n_count    = '0;
                    if (t_action'(i_req.action) == ACT_ALLOC) begin
                        if (r_top == '0) begin
                            n_status = STAT_EMPTY;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_POP;
                        end
                    end else if (i_req.page_addr[PAGE_SHIFT-1:0] != '0) begin
                        n_status = STAT_BADADDR;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_KEND;
                    end
                end
            end
            // reject below kernel end
            ST_KEND: begin
                if (!alu_carry) begin
                    n_status = STAT_BADADDR;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_TOP;
                end
            end
            // reject at or above top
            ST_TOP: begin
                if (alu_carry) begin
                    n_status = STAT_BADADDR;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_BASE;
                end
            end
            // reject below base or past the last page, else form the index
            ST_BASE: begin
                if (!alu_carry || ((ADDR_W + 1)'(alu_page) >= (ADDR_W + 1)'(NUM_PAGES)))
                begin
                    n_status = STAT_BADADDR;
                    n_state  = ST_DONE;
                end else begin
                    n_idx   = IDX_W'(alu_page);
                    n_state = ST_RD;
                end
            end
            // count memory read in flight
            ST_RD: begin
                n_state = ST_RMW;
            end
            ST_RMW: begin
                n_state = ST_DONE;
                if (r_action == ACT_INC) begin
                    if (r_ref_rd == CNT_MAX) begin
                        n_status = STAT_FULL;
                        n_count  = CNT_MAX;
                    end else begin
                        ref_we    = 1'b1;
                        ref_wdata = r_ref_rd + CNT_W'(1);
                        n_count   = r_ref_rd + CNT_W'(1);
                    end
                end else if (cnt_base == '0) begin
                    n_status = STAT_UNDER;
                    n_count  = '0;
                end else begin
                    ref_we    = 1'b1;
                    ref_wdata = cnt_dec;
                    n_count   = cnt_dec;
                    if (cnt_dec == '0) begin
                        if (r_top < TOP_W'(NUM_PAGES)) begin
                            stk_we     = 1'b1;
                            n_top      = r_top + TOP_W'(1);
                            n_released = 1'b1;
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end
                end
            end
            // pop the free stack
            ST_POP: begin
                n_top   = r_top - TOP_W'(1);
                n_state = ST_GRANT;
            end
            // claim the page and form its address
            ST_GRANT: begin
                ref_we    = 1'b1;
                ref_waddr = r_stk_rd;
                ref_wdata = CNT_W'(1);
                n_idx     = r_stk_rd;
                n_count   = CNT_W'(1);
                n_granted = alu_res[ADDR_W-1:0];
                n_state   = ST_DONE;
            end
            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_status   = r_status;
                    n_out_granted  = r_granted;
                    n_out_released = r_released;
                    n_out_count    = r_count;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_action       <= n_action;
        r_pa           <= n_pa;
        r_idx          <= n_idx;
        r_status       <= n_status;
        r_granted      <= n_granted;
        r_released     <= n_released;
        r_count        <= n_count;
        r_out_status   <= n_out_status;
        r_out_granted  <= n_out_granted;
        r_out_released <= n_out_released;
        r_out_count    <= n_out_count;
    end

    // reference count memory
    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        r_ref_rd <= ref_mem[r_idx];
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[r_top[IDX_W-1:0]] <= r_idx;
        end
        r_stk_rd <= stk_mem[stk_raddr];
    end

endmodule
